>>> hdl/ecos_pkg.sv
// shared types and constants for the euler-cromer orbit step block
`default_nettype none
package ecos_pkg;

  // gravitational constant 4*pi^2 with 40 fraction bits
  localparam logic [63:0] G_Q40 = 64'd43406979202193;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_POS_X = 3'd0;
  localparam logic [2:0] CFG_POS_Y = 3'd1;
  localparam logic [2:0] CFG_POS_Z = 3'd2;
  localparam logic [2:0] CFG_VEL_X = 3'd3;
  localparam logic [2:0] CFG_VEL_Y = 3'd4;
  localparam logic [2:0] CFG_VEL_Z = 3'd5;
  localparam logic [2:0] CFG_DT    = 3'd6;

  localparam logic [31:0] DT_RESET = 32'd4294967;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ    = 10'b0000000010,
    S_SQRT  = 10'b0000000100,
    S_LDQ   = 10'b0000001000,
    S_DIVQ  = 10'b0000010000,
    S_MULG  = 10'b0000100000,
    S_DIVA  = 10'b0001000000,
    S_MULDV = 10'b0010000000,
    S_MULDP = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

endpackage
`default_nettype wire

>>> hdl/euler_cromer_orbit_step_top.sv
// euler-cromer orbit step: sequencer, shared multiplier and shift-subtract unit
`default_nettype none
// One body around a unit central mass at the origin, advanced one euler-cromer
// step per input word (restart_i = 0) or reloaded from the init registers
// (restart_i = 1). Each result word carries the state after that input word.
// A zero-radius word holds the state and, like a restart word, goes straight
// to S_OUT, which loads the result register once it is free and raises
// out_valid_o; the next input word is taken once the block is back in S_IDLE.
// A normal step runs S_SQ (32x32 partial products for r^2), S_SQRT (the
// bit-pair square root), then per axis S_LDQ (load), two restoring divisions
// (direction cosine, then by r^2) and three products, and S_OUT to load the
// result, all on one multiplier and one shift-subtract unit.
// in_stall_o is high while a word is in work; a finished result is held in
// its own output register, so a new input word can be taken while the
// previous result still waits on out_stall_i. Configuration writes are
// taken at any time and should only be issued while the block is idle.
module euler_cromer_orbit_step_top #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [WORD_BITS-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 restart_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_BITS-1:0]      pos_x_o,
  output logic [WORD_BITS-1:0]      pos_y_o,
  output logic [WORD_BITS-1:0]      pos_z_o,
  output logic [WORD_BITS-1:0]      vel_x_o,
  output logic [WORD_BITS-1:0]      vel_y_o,
  output logic [WORD_BITS-1:0]      vel_z_o,
  output logic                      singular_o
);
  import ecos_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [63:0] SIGN_MAG = 64'd1 << (W - 1);
  localparam logic [63:0] POS_MAX  = SIGN_MAG - 64'd1;
  // G rounded half up to FRAC_BITS fraction bits
  localparam logic [63:0] GFIX =
    64'((G_Q40 + ((64'd1 << (40 - FRAC_BITS)) >> 1)) >> (40 - FRAC_BITS));

  // magnitude of a signed word
  function automatic logic [63:0] mag_of(input logic [W-1:0] raw);
    logic [W-1:0] t;
    t = raw[W-1] ? ('0 - raw) : raw;
    return 64'(t);
  endfunction

  // sign-magnitude add, saturated to the word
  function automatic logic [W-1:0] add_sm(input logic an, input logic [63:0] am,
                                          input logic bn, input logic [63:0] bm);
    logic [64:0] s;
    logic [63:0] mag;
    logic [63:0] negm;
    logic        neg;
    if (an == bn) begin
      s   = {1'b0, am} + {1'b0, bm};
      mag = s[64] ? '1 : s[63:0];
      neg = an;
    end else if (am >= bm) begin
      mag = am - bm;
      neg = an;
    end else begin
      mag = bm - am;
      neg = bn;
    end
    if (neg && (mag != '0)) begin
      if (mag > SIGN_MAG) mag = SIGN_MAG;
      negm = 64'd0 - mag;
      return negm[W-1:0];
    end else begin
      if (mag > POS_MAX) mag = POS_MAX;
      return mag[W-1:0];
    end
  endfunction

  // drop the fraction of a product, saturated to 64 bits
  function automatic logic [63:0] shr_sat(input logic [127:0] x);
    logic [127:0] s;
    s = x >> FRAC_BITS;
    return (|s[127:64]) ? '1 : s[63:0];
  endfunction

  // configuration registers
  logic [W-1:0] ipos_q [3];
  logic [W-1:0] ivel_q [3];
  logic [31:0]  dt_q;

  // architectural state and sequencer
  state_e       state_q, state_d;
  logic [W-1:0] pos_q [3], pos_d [3];
  logic [W-1:0] vel_q [3], vel_d [3];
  logic [6:0]   cnt_q, cnt_d;
  logic [1:0]   ax_q, ax_d;
  logic         sing_q, sing_d;
  logic         pn_q [3], pn_d [3];
  logic [63:0]  pm_q [3], pm_d [3];

  // datapath registers
  logic [127:0] acc_q, acc_d;
  logic [127:0] num_q, num_d;
  logic [128:0] rem_q, rem_d;
  logic [63:0]  quo_q, quo_d;
  logic         ovf_q, ovf_d;
  logic [127:0] r2_q, r2_d;
  logic [63:0]  rw_q, rw_d;
  logic [63:0]  opnd_q, opnd_d;

  // result register
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] opos_q [3];
  logic [W-1:0] ovel_q [3];
  logic         osing_q;
  logic         out_load;

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // shared 32x32 multiplier, one partial product a cycle
  logic [63:0]  op_a, op_b;
  logic [31:0]  mul_ah, mul_bh;
  logic [63:0]  mul_pp;
  logic [127:0] mul_sum;
  logic [63:0]  pm_cur;

  assign pm_cur = pm_q[ax_q];

  always_comb begin
    unique case (state_q)
      S_MULG:  begin op_a = GFIX;   op_b = opnd_q;        end
      S_MULDV: begin op_a = opnd_q; op_b = 64'(dt_q);     end
      S_MULDP: begin op_a = opnd_q; op_b = 64'(dt_q);     end
      default: begin op_a = pm_cur; op_b = pm_cur;        end
    endcase
  end

  assign mul_ah = cnt_q[1] ? op_a[63:32] : op_a[31:0];
  assign mul_bh = cnt_q[0] ? op_b[63:32] : op_b[31:0];
  assign mul_pp = 64'(mul_ah) * 64'(mul_bh);

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    mul_sum = acc_q + 128'(mul_pp);
      2'd3:    mul_sum = acc_q + (128'(mul_pp) << 64);
      default: mul_sum = acc_q + (128'(mul_pp) << 32);
    endcase
  end

  // shared shift-subtract unit: restoring divide or bit-pair square root
  logic         sqrt_mode;
  logic [127:0] dsr;
  logic [128:0] ss_sh, ss_sub;
  logic         ss_ge;
  logic [128:0] ss_rem;
  logic [63:0]  quo_nx;
  logic         ovf_nx;
  logic [63:0]  quo_fin;

  assign sqrt_mode = (state_q == S_SQRT);
  assign dsr       = (state_q == S_DIVA) ? r2_q : 128'(rw_q);

  always_comb begin
    if (sqrt_mode) begin
      ss_sh  = {rem_q[126:0], num_q[127:126]};
      ss_sub = {63'd0, quo_q, 2'b01};
    end else begin
      ss_sh  = {rem_q[127:0], num_q[127]};
      ss_sub = {1'b0, dsr};
    end
  end

  assign ss_ge   = (ss_sh >= ss_sub);
  assign ss_rem  = ss_ge ? (ss_sh - ss_sub) : ss_sh;
  assign quo_nx  = {quo_q[62:0], ss_ge};
  // quotient bits at weight 2^64 and up fall in the first 64 steps
  assign ovf_nx  = ovf_q | (ss_ge & !cnt_q[6]);
  assign quo_fin = ovf_nx ? '1 : quo_nx;

  // velocity and position updates of the current axis
  logic [W-1:0] vraw;
  logic [W-1:0] praw;
  assign vraw = add_sm(vel_q[ax_q][W-1], mag_of(vel_q[ax_q]), !pn_q[ax_q],
                       shr_sat(mul_sum));
  assign praw = add_sm(pn_q[ax_q], pm_cur, vel_q[ax_q][W-1], shr_sat(mul_sum));

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ax_d        = ax_q;
    sing_d      = sing_q;
    acc_d       = acc_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    r2_d        = r2_q;
    rw_d        = rw_q;
    opnd_d      = opnd_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    for (int i = 0; i < 3; i++) begin
      pos_d[i] = pos_q[i];
      vel_d[i] = vel_q[i];
      pn_d[i]  = pn_q[i];
      pm_d[i]  = pm_q[i];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (restart_i) begin
            for (int i = 0; i < 3; i++) begin
              pos_d[i] = ipos_q[i];
              vel_d[i] = ivel_q[i];
            end
            sing_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              pn_d[i] = pos_q[i][W-1];
              pm_d[i] = mag_of(pos_q[i]);
            end
            if ((pos_q[0] == '0) && (pos_q[1] == '0) && (pos_q[2] == '0)) begin
              // zero radius: hold the state
              sing_d  = 1'b1;
              state_d = S_OUT;
            end else begin
              sing_d  = 1'b0;
              acc_d   = '0;
              cnt_d   = '0;
              ax_d    = 2'd0;
              state_d = S_SQ;
            end
          end
        end
      end
      S_SQ: begin
        acc_d = mul_sum;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          if (ax_q == 2'd2) begin
            r2_d    = mul_sum;
            num_d   = mul_sum;
            rem_d   = '0;
            quo_d   = '0;
            ax_d    = 2'd0;
            state_d = S_SQRT;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_SQRT: begin
        rem_d = ss_rem;
        quo_d = quo_nx;
        num_d = num_q << 2;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          rw_d    = quo_nx;
          state_d = S_LDQ;
        end
      end
      S_LDQ: begin
        num_d   = 128'(pm_cur) << FRAC_BITS;
        rem_d   = '0;
        quo_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = '0;
        state_d = S_DIVQ;
      end
      S_DIVQ: begin
        rem_d = ss_rem;
        quo_d = quo_nx;
        ovf_d = ovf_nx;
        num_d = num_q << 1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          opnd_d  = quo_fin;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MULG;
        end
      end
      S_MULG: begin
        acc_d = mul_sum;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          // bits shifted past 128 are dropped
          num_d   = mul_sum << FRAC_BITS;
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          state_d = S_DIVA;
        end
      end
      S_DIVA: begin
        rem_d = ss_rem;
        quo_d = quo_nx;
        ovf_d = ovf_nx;
        num_d = num_q << 1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          opnd_d  = quo_fin;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MULDV;
        end
      end
      S_MULDV: begin
        acc_d = mul_sum;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          vel_d[ax_q] = vraw;
          opnd_d      = mag_of(vraw);
          acc_d       = '0;
          cnt_d       = '0;
          state_d     = S_MULDP;
        end
      end
      S_MULDP: begin
        acc_d = mul_sum;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          pos_d[ax_q] = praw;
          cnt_d       = '0;
          if (ax_q == 2'd2) begin
            state_d = S_OUT;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_LDQ;
          end
        end
      end
      S_OUT: begin
        // wait until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ax_q        <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ax_q        <= ax_d;
      sing_q      <= sing_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= pos_d[i];
        vel_q[i] <= vel_d[i];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ipos_q[i] <= '0;
        ivel_q[i] <= '0;
      end
      dt_q <= DT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POS_X: ipos_q[0] <= cfg_data_i;
        CFG_POS_Y: ipos_q[1] <= cfg_data_i;
        CFG_POS_Z: ipos_q[2] <= cfg_data_i;
        CFG_VEL_X: ivel_q[0] <= cfg_data_i;
        CFG_VEL_Y: ivel_q[1] <= cfg_data_i;
        CFG_VEL_Z: ivel_q[2] <= cfg_data_i;
        CFG_DT:    dt_q      <= cfg_data_i[31:0];
        default:   ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    r2_q   <= r2_d;
    rw_q   <= rw_d;
    opnd_q <= opnd_d;
    for (int i = 0; i < 3; i++) begin
      pn_q[i] <= pn_d[i];
      pm_q[i] <= pm_d[i];
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        opos_q[i] <= pos_q[i];
        ovel_q[i] <= vel_q[i];
      end
      osing_q <= sing_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = opos_q[0];
  assign pos_y_o     = opos_q[1];
  assign pos_z_o     = opos_q[2];
  assign vel_x_o     = ovel_q[0];
  assign vel_y_o     = ovel_q[1];
  assign vel_z_o     = ovel_q[2];
  assign singular_o  = osing_q;

  // a restart word goes straight to the result stage
  a_restart_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i) |=> (state_q == S_OUT))
    else $error("restart word did not go to the result stage");

  // the radius used as divisor is never zero
  a_rw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVQ) |-> (rw_q != '0))
    else $error("division by a zero radius");

  // r^2 used as divisor is never zero
  a_r2_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVA) |-> (r2_q != '0))
    else $error("division by a zero r^2");

endmodule
`default_nettype wire
